// ===== design/sse_pkg.sv =====
// Shared constants, types and helper functions of the substring search engine.
package sse_pkg;

  // Pattern and window geometry
  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned IDX_W       = $clog2(PATTERN_MAX);
  localparam int unsigned LEN_W       = 5;

  // Text position counter, one bit wider than the offset so it can saturate
  localparam int unsigned TEXT_MAX    = 65536;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned OFF_W       = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 64;

  // ASCII case bit and lower-case letter range
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST  = 8'h7A;

  typedef logic [PATTERN_MAX-1:0][7:0] win_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 8'd0,
    REG_PATTERN_HIGH   = 8'd1,
    REG_PATTERN_LENGTH = 8'd2,
    REG_FOLD_CASE      = 8'd3
  } cfg_reg_e;

  // Fold a lower-case ASCII letter to upper case when folding is enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
    logic [7:0] r;
    r = b;
    if (fold && (b >= LOWER_FIRST) && (b <= LOWER_LAST)) begin
      r = b ^ CASE_BIT;
    end
    return r;
  endfunction

endpackage

// ===== design/sse_if.sv =====
// Valid/ready channel interfaces for text input, search result and register writes.
interface sse_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sse_result_if import sse_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             found;
  logic [OFF_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface sse_cfg_if import sse_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/substring_search_engine.sv =====
// Top level of the substring search engine: input stage, match state and result register.
// Searches a stream of text words for a pattern of 1 to 16 bytes and, on the word
// flagged end_of_text, returns one result word with a found flag and the offset of the
// first match's first byte (0 if none). Throughput is one text word per clock unless
// the input stalls: every word is shifted into a 16-byte window and compared
// combinationally against the whole pattern. The last word lands in the input register,
// and its compare loads the result register once that register is free. The input
// stalls only when a result is still waiting in the result register and another
// end-of-text word needs it. Pattern length 0 acts as 1, lengths above 16 as 16.
// The position counter saturates at 65536 bytes; matches completing past that are not
// reported. Register writes are taken every cycle and must only be issued while idle.
module substring_search_engine import sse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  sse_text_if.sink           text_i,
  sse_result_if.source       result_o,
  sse_cfg_if.sink            cfg_i
);

  // Configuration registers
  win_t             pattern_q;
  logic [LEN_W-1:0] len_q;
  logic             fold_q;

  // Input stage
  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             s1_last_q;

  // Text state
  win_t             win_q;
  logic [CNT_W-1:0] count_q;
  logic             hit_q;
  logic [OFF_W-1:0] off_q;

  // Result register
  logic             res_valid_q;
  logic             res_found_q;
  logic [OFF_W-1:0] res_off_q;

  logic             s2_take;
  logic             in_fire;
  win_t             win_d;
  logic [LEN_W-1:0] len_eff;
  logic             counted;
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] start;
  logic             win_hit;
  logic             hit_now;
  logic             hit_d;
  logic [OFF_W-1:0] off_d;

  // Handshakes
  assign s2_take      = s1_valid_q && (!s1_last_q || !res_valid_q || result_o.ready);
  assign text_i.ready = !s1_valid_q || s2_take;
  assign in_fire      = text_i.valid && text_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Effective pattern length, clamped to 1..PATTERN_MAX
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  // Window shift and saturating position count
  assign win_d   = {win_q[PATTERN_MAX-2:0], s1_byte_q};
  assign counted = count_q < CNT_W'(TEXT_MAX);
  assign count_d = counted ? count_q + CNT_W'(1) : count_q;
  assign start   = count_d - CNT_W'(len_eff);

  sse_match u_match (
    .win_i     (win_d),
    .pattern_i (pattern_q),
    .len_i     (len_eff),
    .fold_i    (fold_q),
    .hit_o     (win_hit)
  );

  // First match latch; start must fit the offset field
  assign hit_now = !hit_q && counted && (count_d >= CNT_W'(len_eff)) && win_hit &&
                   !start[CNT_W-1];
  assign hit_d   = hit_q || hit_now;
  assign off_d   = hit_now ? start[OFF_W-1:0] : off_q;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LEN_W'(1);
      fold_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_PATTERN_LOW:    pattern_q[7:0]  <= cfg_i.data;
        REG_PATTERN_HIGH:   pattern_q[15:8] <= cfg_i.data;
        REG_PATTERN_LENGTH: len_q           <= cfg_i.data[LEN_W-1:0];
        REG_FOLD_CASE:      fold_q          <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s2_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_i.text_byte;
      s1_last_q <= text_i.end_of_text;
    end
  end

  // Text state: updated per word, cleared after the last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      count_q <= '0;
      hit_q   <= 1'b0;
      off_q   <= '0;
    end else if (s2_take) begin
      if (s1_last_q) begin
        win_q   <= '0;
        count_q <= '0;
        hit_q   <= 1'b0;
        off_q   <= '0;
      end else begin
        win_q   <= win_d;
        count_q <= count_d;
        hit_q   <= hit_d;
        off_q   <= off_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s2_take && s1_last_q) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take && s1_last_q) begin
      res_found_q <= hit_d;
      res_off_q   <= hit_d ? off_d : '0;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.found        = res_found_q;
  assign result_o.match_offset = res_off_q;

endmodule

// ===== design/sse_match.sv =====
// Parallel window compare: checks the newest bytes against the pattern.
module sse_match import sse_pkg::*; (
  input  win_t             win_i,
  input  win_t             pattern_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic             fold_i,
  output logic             hit_o
);

  // Pattern byte i lines up with window byte len-1-i (window[0] is newest)
  logic [PATTERN_MAX-1:0] lane_ok;

  always_comb begin
    logic [LEN_W-1:0] pos;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pos = len_i - LEN_W'(i) - LEN_W'(1);
      if (LEN_W'(i) >= len_i) begin
        lane_ok[i] = 1'b1;
      end else begin
        lane_ok[i] = (fold_byte(win_i[pos[IDX_W-1:0]], fold_i) ==
                      fold_byte(pattern_i[i], fold_i));
      end
    end
  end

  assign hit_o = &lane_ok;

endmodule

// ===== design/sse_checker.sv =====
// Port-level assertions for the substring search engine, bound to the top level.
module sse_checker import sse_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             text_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic             res_found_i,
  input logic [OFF_W-1:0] res_offset_i
);

  // A result word that is not taken stays, unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_found_i) && $stable(res_offset_i))
    else $error("result word dropped or changed while stalled");

  // No match means a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_found_i |-> res_offset_i == '0)
    else $error("nonzero offset without a match");

  // Text input only stalls behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_ready_i |-> res_valid_i && !res_ready_i)
    else $error("text input stalled while result side is free");

  // A stall is released once the result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_ready_i && res_ready_i |=> text_ready_i)
    else $error("text input still stalled after result was taken");

endmodule

bind substring_search_engine sse_checker u_sse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .text_ready_i (text_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_found_i  (result_o.found),
  .res_offset_i (result_o.match_offset)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the substring search engine: directed and random texts.
module testbench;
  import sse_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 3000000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_WORDS  = 1600;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } verdict_t;

  // Tracks pattern registers and text state; queues the verdict due on each end of text
  class match_tracker;
    logic [PATTERN_MAX-1:0][7:0] pat;
    logic [LEN_W-1:0]            len_reg;
    logic                        fold;
    logic [7:0]                  win [PATTERN_MAX];
    logic [CNT_W-1:0]            count;
    logic                        hit;
    logic [OFF_W-1:0]            hit_at;
    verdict_t                    pending[$];
    int                          mismatches;

    function new();
      pat        = '0;
      len_reg    = LEN_W'(1);
      fold       = 1'b0;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (win[i]) win[i] = 8'h00;
      count  = '0;
      hit    = 1'b0;
      hit_at = '0;
    endfunction

    function logic [7:0] upper(logic [7:0] b);
      if (fold && b >= LOWER_FIRST && b <= LOWER_LAST) return b ^ CASE_BIT;
      return b;
    endfunction

    // Effective pattern length: zero acts as one, oversize clips to the window
    function int unsigned span();
      int unsigned n;
      n = len_reg;
      if (n == 0) n = 1;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      return n;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_PATTERN_LOW:    pat[7:0]  = d;
        REG_PATTERN_HIGH:   pat[15:8] = d;
        REG_PATTERN_LENGTH: len_reg   = d[LEN_W-1:0];
        REG_FOLD_CASE:      fold      = d[0];
        default: ;
      endcase
    endfunction

    // Shift one text word in, latch the first match, queue a verdict on end of text
    function void take_byte(logic [7:0] b, logic last);
      int unsigned      n;
      logic             counted;
      logic             same;
      logic [CNT_W-1:0] start;
      verdict_t         v;
      n       = span();
      counted = (count < TEXT_MAX);
      for (int i = PATTERN_MAX - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (counted) count++;
      if (!hit && counted && count >= n) begin
        start = CNT_W'(count - n);
        same  = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (upper(win[n-1-i]) != upper(pat[i])) same = 1'b0;
        end
        if (same && start < TEXT_MAX) begin
          hit    = 1'b1;
          hit_at = start[OFF_W-1:0];
        end
      end
      if (last) begin
        v.found  = hit;
        v.offset = hit ? hit_at : '0;
        pending.push_back(v);
        clear_text();
      end
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task check_verdict(logic found, logic [OFF_W-1:0] offset);
      verdict_t v;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result found=%0d offset=%0d", found, offset));
      end else begin
        v = pending.pop_front();
        if (found !== v.found)
          report($sformatf("found is %0d, expected %0d", found, v.found));
        if (offset !== v.offset)
          report($sformatf("match_offset is %0d, expected %0d", offset, v.offset));
      end
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic quiet  = 1'b0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  match_tracker tracker;

  sse_text_if   text_bus ();
  sse_result_if result_bus ();
  sse_cfg_if    cfg_bus ();

  substring_search_engine DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b | CASE_BIT) >= LOWER_FIRST) && ((b | CASE_BIT) <= LOWER_LAST);
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] b);
    if (is_letter(b) && $urandom_range(0, 1) == 1) return b ^ CASE_BIT;
    return b;
  endfunction

  // Text words biased toward the pattern so partial matches are common
  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return flip_case(tracker.pat[$urandom_range(0, tracker.span() - 1)]);
    if (r < 6) return flip_case(LOWER_FIRST + 8'($urandom_range(0, 25)));
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stalls, check every accepted word
  initial begin
    int stall;
    stall = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_bus.valid && result_bus.ready)
        tracker.check_verdict(result_bus.found, result_bus.match_offset);
      if (stall > 0) begin
        stall--;
        result_bus.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        result_bus.ready <= (stall == 0);
      end
    end
  end

  task automatic send_text(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      text_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_bus.valid       <= 1'b1;
    text_bus.text_byte   <= b;
    text_bus.end_of_text <= last;
    do @(posedge clk_i); while (!text_bus.ready);
    tracker.take_byte(b, last);
    words_sent++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    tracker.write_reg(idx, data);
  endtask

  // Wait until every verdict is back and the pipeline has drained
  task automatic wait_idle();
    text_bus.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Full register load, upper data bits random; sometimes a write to an unused index
  task automatic set_pattern(input logic [PATTERN_MAX-1:0][7:0] p,
                             input logic [LEN_W-1:0] len_raw, input logic fold_bit);
    logic [63:0] lw;
    logic [63:0] fw;
    lw = rand64();
    lw[LEN_W-1:0] = len_raw;
    fw = rand64();
    fw[0] = fold_bit;
    wait_idle();
    if ($urandom_range(0, 2) == 0)
      write_cfg(CFG_IDX_W'($urandom_range(int'(REG_FOLD_CASE) + 1, 2**CFG_IDX_W - 1)),
                rand64());
    write_cfg(REG_PATTERN_LOW, p[7:0]);
    write_cfg(REG_PATTERN_HIGH, p[15:8]);
    write_cfg(REG_PATTERN_LENGTH, lw);
    write_cfg(REG_FOLD_CASE, fw);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [PATTERN_MAX-1:0][7:0] p;
    logic [LEN_W-1:0]            len_raw;
    int                          r;
    foreach (p[i]) begin
      if ($urandom_range(0, 1) == 1) p[i] = flip_case(LOWER_FIRST + 8'($urandom_range(0, 25)));
      else p[i] = 8'($urandom_range(0, 255));
    end
    r = $urandom_range(0, 19);
    if (r == 0) len_raw = '0;
    else if (r == 1) len_raw = LEN_W'($urandom_range(PATTERN_MAX + 1, 2**LEN_W - 1));
    else if (r < 6) len_raw = LEN_W'($urandom_range(9, PATTERN_MAX));
    else len_raw = LEN_W'($urandom_range(1, 8));
    set_pattern(p, len_raw, 1'($urandom_range(0, 1)));
  endtask

  // Single register change in the middle of a text
  task automatic tweak_config();
    logic [63:0] d;
    d = rand64();
    wait_idle();
    case ($urandom_range(0, 2))
      0: write_cfg(REG_FOLD_CASE, d);
      1: begin
        d[LEN_W-1:0] = LEN_W'($urandom_range(1, PATTERN_MAX));
        write_cfg(REG_PATTERN_LENGTH, d);
      end
      default: write_cfg(REG_PATTERN_LOW, d);
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  // Random text, usually with the pattern planted, sometimes damaged
  task automatic send_random_text();
    logic [7:0] chars[$];
    int n;
    int at;
    int len;
    int split;
    len = tracker.span();
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 400)
      : ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    for (int k = 0; k < n; k++) chars.push_back(text_char());
    if (n >= len && $urandom_range(0, 4) != 0) begin
      at = $urandom_range(0, n - len);
      for (int k = 0; k < len; k++) chars[at+k] = flip_case(tracker.pat[k]);
      if ($urandom_range(0, 5) == 0)
        chars[at + $urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
    end
    split = (n > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : 0;
    for (int k = 0; k < n; k++) begin
      if (split != 0 && k == split) tweak_config();
      send_text(chars[k], k == n - 1);
    end
  endtask

  initial begin
    logic [PATTERN_MAX-1:0][7:0] p;
    tracker = new();
    text_bus.valid       <= 1'b0;
    text_bus.text_byte   <= 8'h00;
    text_bus.end_of_text <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset pattern is one zero byte; match ends on the last word
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);

    // All-ones pattern, oversize length clips to the full window
    set_pattern('1, LEN_W'(2**LEN_W - 1), 1'b0);
    for (int k = 0; k < PATTERN_MAX; k++) send_text(8'hFF, k == PATTERN_MAX - 1);

    // Length zero acts as one, folded compare
    p = '0;
    p[0] = LOWER_FIRST;
    set_pattern(p, '0, 1'b1);
    send_text(LOWER_LAST, 1'b0);
    send_text(LOWER_FIRST ^ CASE_BIT, 1'b1);

    // Folding switched on mid-text applies to words already in the window
    p[1] = LOWER_LAST;
    set_pattern(p, LEN_W'(2), 1'b0);
    send_text(8'h00, 1'b0);
    send_text(LOWER_FIRST ^ CASE_BIT, 1'b0);
    wait_idle();
    write_cfg(REG_FOLD_CASE, {rand64()} | 64'h1);
    cfg_bus.valid <= 1'b0;
    send_text(LOWER_LAST, 1'b1);

    // Text shorter than the pattern: no match
    foreach (p[i]) p[i] = 8'($urandom_range(0, 255));
    set_pattern(p, LEN_W'(5), 1'($urandom_range(0, 1)));
    send_text(p[0], 1'b0);
    send_text(p[1], 1'b1);

    // Random phases
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      quiet = 1'b0;
      random_config();
      quiet = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 8)) send_random_text();
    end

    quiet = 1'b0;
    wait_idle();
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
